// ===== rtl/hcfb_pkg.sv =====
// Shared types, constants and register codes for the humidity colour fade and blink unit.
package hcfb_pkg;

  // Default fixed-point and counter sizes
  localparam int unsigned FRAC_BITS_DEF   = 8;
  localparam int unsigned PHASE_WIDTH_DEF = 16;

  // Register file geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned LEVEL_W    = 10;

  // Humidity range in tenths of a percent
  localparam int unsigned SAMPLE_W = 12;
  localparam logic [LEVEL_W-1:0] HUM_MID   = 10'd500;
  localparam logic [LEVEL_W-1:0] HUM_MAX   = 10'd1000;

  // Reset values of the registers
  localparam logic [PERIOD_W-1:0] UPDATE_PERIOD_RST = 16'd50;
  localparam logic [PERIOD_W-1:0] FAST_HALF_RST     = 16'd10;
  localparam logic [PERIOD_W-1:0] SLOW_HALF_RST     = 16'd25;
  localparam logic [LEVEL_W-1:0]  CRIT_COLD_RST     = 10'd300;
  localparam logic [LEVEL_W-1:0]  COOL_RST          = 10'd400;
  localparam logic [LEVEL_W-1:0]  NORMAL_RST        = 10'd600;
  localparam logic [LEVEL_W-1:0]  HOT_RST           = 10'd800;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPDATE_PERIOD = 3'd0,
    REG_FAST_HALF     = 3'd1,
    REG_SLOW_HALF     = 3'd2,
    REG_CRIT_COLD     = 3'd3,
    REG_COOL          = 3'd4,
    REG_NORMAL        = 3'd5,
    REG_HOT           = 3'd6
  } cfg_idx_e;

  // Register contents as seen by the datapath
  typedef struct packed {
    logic [PERIOD_W-1:0] update_period;
    logic [PERIOD_W-1:0] fast_half_period;
    logic [PERIOD_W-1:0] slow_half_period;
    logic [LEVEL_W-1:0]  critical_cold_level;
    logic [LEVEL_W-1:0]  cool_level;
    logic [LEVEL_W-1:0]  normal_level;
    logic [LEVEL_W-1:0]  hot_level;
  } cfg_t;

endpackage

// ===== rtl/hcfb_cfg_regs.sv =====
// Configuration register file with a plain write port.
module hcfb_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hcfb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hcfb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output hcfb_pkg::cfg_t                   cfg_o
);

  hcfb_pkg::cfg_t cfg_q, cfg_d;

  // Write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (hcfb_pkg::cfg_idx_e'(cfg_idx_i))
        hcfb_pkg::REG_UPDATE_PERIOD: cfg_d.update_period    = cfg_wdata_i;
        hcfb_pkg::REG_FAST_HALF:     cfg_d.fast_half_period = cfg_wdata_i;
        hcfb_pkg::REG_SLOW_HALF:     cfg_d.slow_half_period = cfg_wdata_i;
        hcfb_pkg::REG_CRIT_COLD:
          cfg_d.critical_cold_level = cfg_wdata_i[hcfb_pkg::LEVEL_W-1:0];
        hcfb_pkg::REG_COOL:   cfg_d.cool_level   = cfg_wdata_i[hcfb_pkg::LEVEL_W-1:0];
        hcfb_pkg::REG_NORMAL: cfg_d.normal_level = cfg_wdata_i[hcfb_pkg::LEVEL_W-1:0];
        hcfb_pkg::REG_HOT:    cfg_d.hot_level    = cfg_wdata_i[hcfb_pkg::LEVEL_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.update_period       <= hcfb_pkg::UPDATE_PERIOD_RST;
      cfg_q.fast_half_period    <= hcfb_pkg::FAST_HALF_RST;
      cfg_q.slow_half_period    <= hcfb_pkg::SLOW_HALF_RST;
      cfg_q.critical_cold_level <= hcfb_pkg::CRIT_COLD_RST;
      cfg_q.cool_level          <= hcfb_pkg::COOL_RST;
      cfg_q.normal_level        <= hcfb_pkg::NORMAL_RST;
      cfg_q.hot_level           <= hcfb_pkg::HOT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hcfb_track.sv =====
// Input stage: held humidity, phase counters, blink band and target colour mapping.
module hcfb_track #(
  parameter int unsigned FRAC_BITS   = hcfb_pkg::FRAC_BITS_DEF,
  parameter int unsigned PHASE_WIDTH = hcfb_pkg::PHASE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hcfb_pkg::cfg_t                    cfg_i,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [hcfb_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                              sample_valid_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [FRAC_BITS+7:0]              tgt_r_o,
  output logic [FRAC_BITS+7:0]              tgt_g_o,
  output logic [FRAC_BITS+7:0]              tgt_b_o,
  output logic                              on_o
);

  localparam int unsigned LW   = hcfb_pkg::LEVEL_W;
  localparam int unsigned PW   = hcfb_pkg::PERIOD_W;
  localparam int unsigned TW   = FRAC_BITS + 8;          // colour width
  localparam int unsigned KW   = 17;                     // level * distance
  localparam int unsigned XW   = FRAC_BITS + 15;         // dividend width
  localparam int unsigned SH   = XW + 7;                 // reciprocal shift
  localparam int unsigned PRW  = 2 * XW + 1;             // product width
  localparam int unsigned CW   = (PHASE_WIDTH > PW) ? PHASE_WIDTH : PW;
  localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'd124) / 64'd125;
  localparam logic [XW:0] RECIP   = RECIP64[XW:0];
  localparam logic [XW-1:0] HALF_DIV = XW'(62);
  localparam logic [TW-1:0] G_BASE   = TW'(128) << FRAC_BITS;

  // Scaled division by 125 as a reciprocal multiply, rounded to nearest, exact over the dividend range
  function automatic logic [TW-1:0] div125(input logic [KW-1:0] k);
    logic [XW-1:0]  x;
    logic [PRW-1:0] prod;
    x    = (XW'(k) << (FRAC_BITS - 2)) + HALF_DIV;
    prod = PRW'(x) * PRW'(RECIP);
    return prod[SH +: TW];
  endfunction

  // One phase step: wrap flag above the next count
  function automatic logic [PHASE_WIDTH:0] advance(input logic [PHASE_WIDTH-1:0] ph,
                                                   input logic [PW-1:0] per);
    logic [PW-1:0]          p1;
    logic [PHASE_WIDTH-1:0] nx;
    logic                   hit;
    p1  = (per == '0) ? PW'(1) : per;
    nx  = ph + 1'b1;
    hit = (CW'(nx) >= CW'(p1));
    return {hit, hit ? '0 : nx};
  endfunction

  logic [LW-1:0]          held_q, held_d;
  logic [TW-1:0]          tr_q, tg_q, tb_q;
  logic [TW-1:0]          tr_d, tg_d, tb_d;
  logic [PHASE_WIDTH-1:0] upd_ph_q, fast_ph_q, slow_ph_q;
  logic [PHASE_WIDTH:0]   upd_adv, fast_adv, slow_adv;
  logic                   fast_tog_q, slow_tog_q;
  logic                   valid_q, on_q, on_d;
  logic [TW-1:0]          pr_q, pg_q, pb_q;
  logic                   accept, upd;
  logic [LW-1:0]          clamped, n_lo, dh, dg;
  logic [KW:0]            kx_hi, ky_lo, ky_hi;
  logic [KW-1:0]          kx, ky;
  logic [TW-1:0]          qx, qy;
  logic                   lo, fast_band, steady_band;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;
  assign upd     = (upd_ph_q == '0);

  // Clamp the sample into 0..1000
  always_comb begin
    if (sample_i[hcfb_pkg::SAMPLE_W-1]) begin
      clamped = '0;
    end else if (sample_i[hcfb_pkg::SAMPLE_W-2:0] > 11'(hcfb_pkg::HUM_MAX)) begin
      clamped = hcfb_pkg::HUM_MAX;
    end else begin
      clamped = sample_i[LW-1:0];
    end
  end

  assign held_d = (upd && sample_valid_i) ? clamped : held_q;

  // Piecewise linear map: grey to green, then green to red
  always_comb begin
    lo    = (held_d <= hcfb_pkg::HUM_MID);
    n_lo  = hcfb_pkg::HUM_MID - held_d;
    dh    = held_d - hcfb_pkg::HUM_MID;
    dg    = hcfb_pkg::HUM_MAX - held_d;
    kx_hi = {dh, 8'b0} - (KW+1)'(dh);
    ky_lo = {1'b0, held_d, 7'b0} - (KW+1)'(held_d);
    ky_hi = {dg, 8'b0} - (KW+1)'(dg);
    kx    = lo ? {n_lo, 7'b0} : kx_hi[KW-1:0];
    ky    = lo ? ky_lo[KW-1:0] : ky_hi[KW-1:0];
    qx    = div125(kx);
    qy    = div125(ky);
    if (upd) begin
      tr_d = qx;
      tg_d = lo ? (G_BASE + qy) : qy;
      tb_d = lo ? qx : '0;
    end else begin
      tr_d = tr_q;
      tg_d = tg_q;
      tb_d = tb_q;
    end
  end

  // Blink band from the held humidity and the toggles as they stand
  always_comb begin
    fast_band   = (held_d < cfg_i.critical_cold_level) || (held_d >= cfg_i.hot_level);
    steady_band = (held_d >= cfg_i.cool_level) && (held_d < cfg_i.normal_level);
    if (fast_band) begin
      on_d = !fast_tog_q;
    end else if (steady_band) begin
      on_d = 1'b1;
    end else begin
      on_d = !slow_tog_q;
    end
  end

  assign upd_adv  = advance(upd_ph_q, cfg_i.update_period);
  assign fast_adv = advance(fast_ph_q, cfg_i.fast_half_period);
  assign slow_adv = advance(slow_ph_q, cfg_i.slow_half_period);

  // Tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= hcfb_pkg::HUM_MID;
      tr_q       <= '0;
      tg_q       <= '0;
      tb_q       <= '0;
      upd_ph_q   <= '0;
      fast_ph_q  <= '0;
      slow_ph_q  <= '0;
      fast_tog_q <= 1'b0;
      slow_tog_q <= 1'b0;
    end else if (accept) begin
      held_q     <= held_d;
      tr_q       <= tr_d;
      tg_q       <= tg_d;
      tb_q       <= tb_d;
      upd_ph_q   <= upd_adv[PHASE_WIDTH-1:0];
      fast_ph_q  <= fast_adv[PHASE_WIDTH-1:0];
      slow_ph_q  <= slow_adv[PHASE_WIDTH-1:0];
      fast_tog_q <= fast_tog_q ^ fast_adv[PHASE_WIDTH];
      slow_tog_q <= slow_tog_q ^ slow_adv[PHASE_WIDTH];
    end
  end

  // Stage register towards the fade
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pr_q <= tr_d;
      pg_q <= tg_d;
      pb_q <= tb_d;
      on_q <= on_d;
    end
  end

  assign valid_o = valid_q;
  assign tgt_r_o = pr_q;
  assign tgt_g_o = pg_q;
  assign tgt_b_o = pb_q;
  assign on_o    = on_q;

endmodule

// ===== rtl/hcfb_fade.sv =====
// Output stage: colour fade toward the target and the result register.
module hcfb_fade #(
  parameter int unsigned FRAC_BITS = hcfb_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [FRAC_BITS+7:0]  tgt_r_i,
  input  logic [FRAC_BITS+7:0]  tgt_g_i,
  input  logic [FRAC_BITS+7:0]  tgt_b_i,
  input  logic                  on_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [23:0]           colour_o,
  output logic                  on_o
);

  localparam int unsigned TW = FRAC_BITS + 8;
  localparam int unsigned MW = FRAC_BITS + 12;
  localparam logic [MW-1:0] STEP_RND = MW'(128);

  logic [TW-1:0] tgt   [3];
  logic [TW-1:0] cur_q [3];
  logic [TW-1:0] cur_d [3];
  logic [TW-1:0] diff  [3];
  logic [MW-1:0] scaled[3];
  logic [TW-1:0] step  [3];
  logic [23:0]   colour_d, colour_q;
  logic          valid_q, on_q, accept;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  assign tgt[0] = tgt_r_i;
  assign tgt[1] = tgt_g_i;
  assign tgt[2] = tgt_b_i;

  // Move each channel by 13/256 of the gap, rounded half away from zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]   = (tgt[i] >= cur_q[i]) ? (tgt[i] - cur_q[i]) : (cur_q[i] - tgt[i]);
      scaled[i] = (MW'(diff[i]) << 3) + (MW'(diff[i]) << 2) + MW'(diff[i]) + STEP_RND;
      step[i]   = TW'(scaled[i] >> 8);
      cur_d[i]  = (tgt[i] >= cur_q[i]) ? (cur_q[i] + step[i]) : (cur_q[i] - step[i]);
      colour_d[8*i +: 8] = on_i ? cur_d[i][FRAC_BITS +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= '0;
      end
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        for (int i = 0; i < 3; i++) begin
          cur_q[i] <= cur_d[i];
        end
      end
      if (ready_o) begin
        valid_q <= valid_i;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      colour_q <= colour_d;
      on_q     <= on_i;
    end
  end

  assign valid_o  = valid_q;
  assign colour_o = colour_q;
  assign on_o     = on_q;

endmodule

// ===== rtl/humidity_color_fade_blink_unit.sv =====
// Top level of the humidity colour fade and blink unit.
//
// Each item on the slave stream is one frame tick. tdata carries the signed
// humidity sample in tenths of a percent, tuser says whether it is present.
// Every accepted tick gives exactly one item on the master stream: red,
// green and blue in tdata, and in tuser whether the lamp shows the colour.
// Registers are to be written through the plain write port only while no
// tick is in flight; the block itself does not enforce this. They take
// effect from the next accepted tick. Between acceptance and the master
// side, the first register holds the sample decision, blink band and mapped
// target colour (one reciprocal multiply per channel group), the second the
// faded colour. Throughput is one tick per cycle when nothing stalls.
// When the receiver stalls the result holds; the input stage keeps taking
// ticks until both registers are full, then tready falls.
// Reset sets the registers to their defaults, the held humidity to fifty
// percent, the colours to black and all phase counters to zero, so the
// first tick after reset is an update tick.
module humidity_color_fade_blink_unit #(
  parameter int unsigned FRAC_BITS   = hcfb_pkg::FRAC_BITS_DEF,
  parameter int unsigned PHASE_WIDTH = hcfb_pkg::PHASE_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [hcfb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hcfb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // tick stream in
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [15:0]                      s_axis_tdata_i,  // [11:0] humidity_sample
  input  logic [0:0]                       s_axis_tuser_i,  // [0] sample_valid
  // colour stream out
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [23:0]                      m_axis_tdata_o,  // [7:0] red, [15:8] green,
                                                            // [23:16] blue
  output logic [0:0]                       m_axis_tuser_o   // [0] lamp_on
);

  localparam int unsigned TW = FRAC_BITS + 8;

  hcfb_pkg::cfg_t cfg;
  logic           mid_valid, mid_ready, mid_on;
  logic [TW-1:0]  mid_r, mid_g, mid_b;

  hcfb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hcfb_track #(
    .FRAC_BITS   (FRAC_BITS),
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_track (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .valid_i        (s_axis_tvalid_i),
    .ready_o        (s_axis_tready_o),
    .sample_i       (s_axis_tdata_i[hcfb_pkg::SAMPLE_W-1:0]),
    .sample_valid_i (s_axis_tuser_i[0]),
    .valid_o        (mid_valid),
    .ready_i        (mid_ready),
    .tgt_r_o        (mid_r),
    .tgt_g_o        (mid_g),
    .tgt_b_o        (mid_b),
    .on_o           (mid_on)
  );

  hcfb_fade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (mid_valid),
    .ready_o  (mid_ready),
    .tgt_r_i  (mid_r),
    .tgt_g_i  (mid_g),
    .tgt_b_i  (mid_b),
    .on_i     (mid_on),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .colour_o (m_axis_tdata_o),
    .on_o     (m_axis_tuser_o[0])
  );

endmodule

// ===== rtl/hcfb_checker.sv =====
// Port-level checks on the top level, bound in below.
module hcfb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);

  // A blinked-off item is black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == 24'd0))
    else $error("lamp off but colour not black");

  // An empty output side never holds off the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with no result pending");

  // An accepted tick is followed by a valid result on the master side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> ##2 m_axis_tvalid_o)
    else $error("result missing after accepted tick");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind humidity_color_fade_blink_unit hcfb_checker u_hcfb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
